@@ hdl/tsnb_pkg.sv @@
// shared constants for the texture sampler core
// no dependencies
package tsnb_pkg;
    localparam int MAX_SIDE       = 256;
    localparam int SIDE_BITS      = 9;
    localparam int IDX_BITS       = 8;
    localparam int ADDR_BITS      = 16;
    localparam int FRAC_BITS      = 16;
    localparam int CHAN_BITS      = 8;
    localparam int TEXEL_BITS     = 3 * CHAN_BITS;
    localparam int STORE_DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int X_BITS         = FRAC_BITS + SIDE_BITS;
    localparam int Y_BITS         = FRAC_BITS + 1 + SIDE_BITS;
    localparam int WGT_BITS       = 2 * FRAC_BITS + 1;
    localparam int ACC_BITS       = WGT_BITS + CHAN_BITS;
    localparam int IN_DATA_BITS   = 72;
    localparam int OUT_DATA_BITS  = 24;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE  = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef logic [IDX_BITS-1:0] t_idx;
endpackage

@@ hdl/texture_sampler_nearest_bilinear_core.sv @@
// texture sampler core: texel store, nearest and bilinear filtering
// depends on tsnb_pkg
//
// channel   dir  tdata (low bit up)                                   tuser
// s         in   texel_index, red, green, blue, coord_u, coord_v      command
// m         out  sample_red, sample_green, sample_blue                -
// cfg       in   i_cfg_index 0 width, 1 height, 2 filter mode
//
// one word per cycle while no result waits at the output; five register stages from input to output word
// the store is replicated four times so every sample reads its four texels at once
// reset clears valid flags and sets the configuration to 256 by 256, bilinear; the store is undefined until written
// a result waiting at the output stalls the whole pipe, bubbles keep flowing otherwise
module texture_sampler_nearest_bilinear_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [1:0]                          i_cfg_index,
    input  logic [tsnb_pkg::SIDE_BITS-1:0]      i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // texel_index, texel_red, texel_green, texel_blue, coord_u, coord_v
    input  logic [tsnb_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    // command
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // sample_red, sample_green, sample_blue
    output logic [tsnb_pkg::OUT_DATA_BITS-1:0]  o_m_tdata
);
    import tsnb_pkg::*;

    localparam logic [X_BITS-1:0] HALF_X = X_BITS'(1 << (FRAC_BITS - 1));
    localparam logic [Y_BITS-1:0] HALF_Y = Y_BITS'(1 << (FRAC_BITS - 1));
    localparam logic [FRAC_BITS:0] ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [SIDE_BITS-1:0] r_width, r_height;
    logic                 r_mode;
    logic [SIDE_BITS-1:0] w_side, h_side;
    logic                 en;

    logic [TEXEL_BITS-1:0] mem0 [STORE_DEPTH];
    logic [TEXEL_BITS-1:0] mem1 [STORE_DEPTH];
    logic [TEXEL_BITS-1:0] mem2 [STORE_DEPTH];
    logic [TEXEL_BITS-1:0] mem3 [STORE_DEPTH];

    // stage 1
    logic r_v1, r_smp1;
    logic [X_BITS-1:0] r_x1;
    logic [Y_BITS-1:0] r_y1;
    logic [ADDR_BITS-1:0] r_widx1;
    logic [TEXEL_BITS-1:0] r_wdat1;
    // stage 2
    logic r_v2, r_smp2;
    t_idx r_c0, r_c1, r_r0, r_r1;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic [ADDR_BITS-1:0] r_widx2;
    logic [TEXEL_BITS-1:0] r_wdat2;
    // stage 3
    logic r_v3;
    logic [TEXEL_BITS-1:0] r_t00, r_t10, r_t01, r_t11;
    logic [WGT_BITS-1:0] r_w00, r_w10, r_w01, r_w11;
    // stage 4
    logic r_v4;
    logic [ACC_BITS-1:0] r_p [3][4];
    // output
    logic r_m_valid;
    logic [OUT_DATA_BITS-1:0] r_m_data;

    assign w_side = (r_width == '0) ? SIDE_BITS'(1) :
                    (r_width > SIDE_BITS'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE) : r_width;
    assign h_side = (r_height == '0) ? SIDE_BITS'(1) :
                    (r_height > SIDE_BITS'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE) : r_height;

    assign en         = !r_m_valid || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_BITS'(MAX_SIDE);
            r_height <= SIDE_BITS'(MAX_SIDE);
            r_mode   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                REG_FILTER_MODE:  r_mode   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_smp2;
            r_v4 <= r_v3;
            r_m_valid <= r_v4;
        end
    end

    // stage 1: scale coordinates, capture command and write fields
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smp1  <= (i_s_tuser == CMD_SAMPLE);
            r_widx1 <= i_s_tdata[15:0];
            r_wdat1 <= i_s_tdata[39:16];
            r_x1    <= X_BITS'(i_s_tdata[55:40]) * X_BITS'(w_side);
            r_y1    <= Y_BITS'(ONE - {1'b0, i_s_tdata[71:56]}) * Y_BITS'(h_side);
        end
    end

    // stage 2: neighbour indices and fractions
    logic [X_BITS-1:0] sx;
    logic [Y_BITS-1:0] sy, ym1;
    logic [SIDE_BITS:0] xa, xb, ya, yb;
    logic [FRAC_BITS-1:0] fx, fy;
    t_idx c0, c1, r0, r1;

    function automatic t_idx sat(input logic [SIDE_BITS:0] i, input logic [SIDE_BITS-1:0] s);
        logic [SIDE_BITS:0] lim;
        lim = {1'b0, s} - 1'b1;
        return (i > lim) ? lim[IDX_BITS-1:0] : i[IDX_BITS-1:0];
    endfunction

    always_comb begin
        sx  = r_x1 - HALF_X;
        sy  = r_y1 - HALF_Y;
        ym1 = r_y1 - 1'b1;
        fx  = '0;
        fy  = '0;
        if (!r_mode) begin
            xa = {1'b0, r_x1[X_BITS-1:FRAC_BITS]};
            xb = xa;
            ya = ym1[Y_BITS-1:FRAC_BITS];
            yb = ya;
        end else begin
            if (r_x1 < HALF_X) begin
                xa = '0; xb = '0;
            end else begin
                xa = {1'b0, sx[X_BITS-1:FRAC_BITS]};
                xb = xa + 1'b1;
                fx = sx[FRAC_BITS-1:0];
            end
            if (r_y1 < HALF_Y) begin
                ya = '0; yb = '0;
            end else begin
                ya = sy[Y_BITS-1:FRAC_BITS];
                yb = ya + 1'b1;
                fy = sy[FRAC_BITS-1:0];
            end
        end
        c0 = sat(xa, w_side);
        c1 = sat(xb, w_side);
        r0 = sat(ya, h_side);
        r1 = sat(yb, h_side);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smp2  <= r_smp1;
            r_widx2 <= r_widx1;
            r_wdat2 <= r_wdat1;
            r_c0 <= c0; r_c1 <= c1; r_r0 <= r0; r_r1 <= r1;
            r_fx <= fx; r_fy <= fy;
        end
    end

    // stage 3: store access and area weights
    logic [ADDR_BITS-1:0] a00, a10, a01, a11;
    logic [FRAC_BITS:0] gx, gy;

    assign a00 = ADDR_BITS'(r_r0) * ADDR_BITS'(w_side) + ADDR_BITS'(r_c0);
    assign a10 = ADDR_BITS'(r_r0) * ADDR_BITS'(w_side) + ADDR_BITS'(r_c1);
    assign a01 = ADDR_BITS'(r_r1) * ADDR_BITS'(w_side) + ADDR_BITS'(r_c0);
    assign a11 = ADDR_BITS'(r_r1) * ADDR_BITS'(w_side) + ADDR_BITS'(r_c1);
    assign gx  = ONE - {1'b0, r_fx};
    assign gy  = ONE - {1'b0, r_fy};

    always_ff @(posedge i_clk) begin
        if (en) begin
            // a write reaches the store in the same stage as sample reads, keeping order
            if (r_v2 && !r_smp2) begin
                mem0[r_widx2] <= r_wdat2;
                mem1[r_widx2] <= r_wdat2;
                mem2[r_widx2] <= r_wdat2;
                mem3[r_widx2] <= r_wdat2;
            end
            r_t00 <= mem0[a00];
            r_t10 <= mem1[a10];
            r_t01 <= mem2[a01];
            r_t11 <= mem3[a11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w00  <= WGT_BITS'(gx) * WGT_BITS'(gy);
            r_w10  <= WGT_BITS'(r_fx) * WGT_BITS'(gy);
            r_w01  <= WGT_BITS'(gx) * WGT_BITS'(r_fy);
            r_w11  <= WGT_BITS'(r_fx) * WGT_BITS'(r_fy);
        end
    end

    // stage 4: per-channel products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_p[ch][0] <= ACC_BITS'(r_t00[ch*CHAN_BITS +: CHAN_BITS]) * ACC_BITS'(r_w00);
                r_p[ch][1] <= ACC_BITS'(r_t10[ch*CHAN_BITS +: CHAN_BITS]) * ACC_BITS'(r_w10);
                r_p[ch][2] <= ACC_BITS'(r_t01[ch*CHAN_BITS +: CHAN_BITS]) * ACC_BITS'(r_w01);
                r_p[ch][3] <= ACC_BITS'(r_t11[ch*CHAN_BITS +: CHAN_BITS]) * ACC_BITS'(r_w11);
            end
        end
    end

    // output: sum, round half up
    logic [ACC_BITS-1:0] acc [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = r_p[ch][0] + r_p[ch][1] + r_p[ch][2] + r_p[ch][3]
                    + (ACC_BITS'(1) << (2*FRAC_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_m_data[ch*CHAN_BITS +: CHAN_BITS] <=
                    acc[ch][2*FRAC_BITS +: CHAN_BITS];
            end
        end
    end
endmodule
